/* design/assert_macros.svh */
// Assertion macros used by the timer bank top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising clock edge outside reset.
`define STB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define STB_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define STB_ASSERT(lbl, clk, rst, prop, msg)
`define STB_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* design/stb_pkg.sv */
// Package with command codes, sequencer states and cell control for the timer bank.
package stb_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } stb_state_t;

  // Control bundle that the sequencer drives into each cell.
  typedef struct packed {
    logic shift;     // move the scan token one cell along
    logic en;        // cell lies inside the scanned range
    logic load;      // load period and one-shot flag, clear count, start
    logic stop;      // clear the running flag
    logic one_shot;  // one-shot flag written on load
  } cell_ctrl_t;

endpackage

/* design/stb_cell.sv */
// One timer slot of the chain: running flag, count, period and the scan token stage.
module stb_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stb_pkg::cell_ctrl_t     ctrl,
  input  logic [COUNT_BITS-1:0]   load_period,
  input  logic                    tok_in,
  output logic                    tok_out,
  output logic                    fire
);

  logic                  tok;
  logic                  running;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] period;
  logic                  one_shot;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  match;
  logic                  visit;

  // The count is compared with the period after the increment.
  assign count_inc = count + COUNT_BITS'(1);
  assign match     = (count_inc == period);
  assign visit     = tok && ctrl.en && running;
  assign fire      = visit && match;
  assign tok_out   = tok;

  // Token stage, running flag and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      running <= 1'b0;
      count   <= '0;
    end else begin
      if (ctrl.shift) begin
        tok <= tok_in;
      end
      if (ctrl.load) begin
        running <= 1'b1;
        count   <= '0;
      end else if (ctrl.stop) begin
        running <= 1'b0;
      end else if (ctrl.shift && visit) begin
        if (match) begin
          count <= '0;
          if (one_shot) begin
            running <= 1'b0;
          end
        end else begin
          count <= count_inc;
        end
      end
    end
  end

  // Period and one-shot flag are only read once a load has written them.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      period   <= load_period;
      one_shot <= ctrl.one_shot;
    end
  end

endmodule

/* design/software_timer_bank_top.sv */
// Top level of the timer bank: command decode, scan sequencer, result buffering.
//
// Input items arrive on cmd_valid/cmd_stall with cmd, slot_index, period and one_shot.
// A load or stop item leaves the sequencer idle and gives no result. A tick item
// sends a scan token down a chain of SLOT_COUNT slot cells, one cell per cycle while
// the walk is not paused; each running cell below tasks_in_use counts up and may
// expire. Every expiry leaves as one result item on fire_valid/fire_stall with
// fired_slot; the last one of a tick has last_fired. After its accepting edge a tick
// holds cmd_stall high through the token walk and the flush state for the final
// result, so the block takes no new item until the tick is through.
// An expiry waits in a pending register until the next expiry of the same tick or the
// flush state sends it out; the last result of a tick is sent from the flush state.
// A stall on the result side holds the result register; if a second expiry then
// needs to go out, the token walk pauses until the receiver takes the first.
// tasks_in_use is written through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// Reset (rst, synchronous) stops all slots, clears counts and sets tasks_in_use to 0.
`include "assert_macros.svh"

module software_timer_bank_top #(
  parameter int SLOT_COUNT = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  slot_index,
  input  logic [15:0] period,
  input  logic        one_shot,
  output logic        fire_valid,
  input  logic        fire_stall,
  output logic [2:0]  fired_slot,
  output logic        last_fired
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  stb_pkg::stb_state_t   state;
  stb_pkg::stb_state_t   state_next;
  logic [3:0]            tasks_in_use;
  logic [SLOT_COUNT:0]   tok_link;
  logic [SLOT_COUNT-1:0] fire_vec;
  logic                  fire_any;
  logic [IDX_W-1:0]      fire_idx;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_slot;
  logic                  cmd_acc;
  logic                  start;
  logic                  out_free;
  logic                  adv;
  logic                  shift_en;
  logic                  emit_mid;
  logic                  emit_last;
  logic [COUNT_BITS-1:0] load_period;

  assign cmd_acc     = cmd_valid && !cmd_stall;
  assign out_free    = !fire_valid || !fire_stall;
  assign load_period = COUNT_BITS'(period);
  assign tok_link[0] = start;

  // Scan length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tasks_in_use <= 4'd0;
    end else if (cfg_wen) begin
      tasks_in_use <= cfg_wdata;
    end
  end

  // Chain of slot cells with the scan token passed from cell to cell.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    stb_pkg::cell_ctrl_t ctrl;

    always_comb begin
      ctrl.shift    = shift_en;
      ctrl.en       = (32'(tasks_in_use) > i);
      ctrl.load     = cmd_acc && (cmd == stb_pkg::CMD_LOAD) && (32'(slot_index) == i);
      ctrl.stop     = cmd_acc && (cmd == stb_pkg::CMD_STOP) && (32'(slot_index) == i);
      ctrl.one_shot = one_shot;
    end

    stb_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .load_period (load_period),
      .tok_in      (tok_link[i]),
      .tok_out     (tok_link[i+1]),
      .fire        (fire_vec[i])
    );
  end

  // The token is one-hot, so at most one cell fires; encode its index.
  always_comb begin
    fire_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (fire_vec[i]) begin
        fire_idx = fire_idx | IDX_W'(i);
      end
    end
  end
  assign fire_any = |fire_vec;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stb_pkg::ST_IDLE: begin
        if (cmd_acc && (cmd == stb_pkg::CMD_TICK)) begin
          state_next = stb_pkg::ST_SCAN;
        end
      end
      stb_pkg::ST_SCAN: begin
        if (adv && tok_link[SLOT_COUNT]) begin
          state_next = stb_pkg::ST_FLUSH;
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = stb_pkg::ST_IDLE;
        end
      end
      default: state_next = stb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. An expiry waits in the pending register until the next one
  // or the end of the tick shows whether it is the last.
  always_comb begin
    cmd_stall = (state != stb_pkg::ST_IDLE);
    start     = cmd_acc && (cmd == stb_pkg::CMD_TICK);
    adv       = !(fire_any && pend_valid && !out_free);
    shift_en  = start || ((state == stb_pkg::ST_SCAN) && adv);
    emit_mid  = (state == stb_pkg::ST_SCAN) && adv && fire_any && pend_valid;
    emit_last = (state == stb_pkg::ST_FLUSH) && pend_valid && out_free;
  end

  // Pending expiry.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if ((state == stb_pkg::ST_SCAN) && adv && fire_any) begin
      pend_valid <= 1'b1;
    end else if (emit_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == stb_pkg::ST_SCAN) && adv && fire_any) begin
      pend_slot <= fire_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_valid <= 1'b0;
    end else if (emit_mid || emit_last) begin
      fire_valid <= 1'b1;
    end else if (!fire_stall) begin
      fire_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_mid || emit_last) begin
      fired_slot <= 3'(pend_slot);
      last_fired <= emit_last;
    end
  end

  // The scan token is in at most one cell.
  `STB_ASSERT(a_tok_onehot, clk, rst, $onehot0(tok_link[SLOT_COUNT:1]), "token not one-hot")
  // No expiry is held over once the sequencer is idle.
  `STB_NEVER(a_idle_pend, clk, rst, (state == stb_pkg::ST_IDLE) && pend_valid, "idle pend")
  // Cells fire only during a scan.
  `STB_ASSERT(a_fire_scan, clk, rst, fire_any |-> (state == stb_pkg::ST_SCAN), "fire off scan")
  // The token has left the chain when the flush begins.
  `STB_NEVER(a_flush_tok, clk, rst, (state == stb_pkg::ST_FLUSH) && (|tok_link[SLOT_COUNT:1]), "flush tok")

endmodule

/* verif/tb.sv */
// Self-checking testbench for the software timer bank, with an expiry scoreboard class.
`timescale 1ns / 100ps

// One expected or observed expiry: the slot that fired and the end-of-tick marker.
typedef struct packed {
  logic [2:0] slot;
  logic       is_last;
} expiry_t;

// Mirrors the timer table and holds the expiries that the block still owes.
class expiry_scoreboard;
  localparam int SLOTS = 8;

  bit        running [SLOTS];
  bit [15:0] elapsed [SLOTS];
  bit [15:0] period_of [SLOTS];
  bit        one_shot_of [SLOTS];
  bit [3:0]  scan_len;
  expiry_t   owed_expiries [$];
  int        errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      running[i] = 1'b0;
      elapsed[i] = '0;
      period_of[i] = '0;
      one_shot_of[i] = 1'b0;
    end
    scan_len = '0;
    errors = 0;
  endfunction

  function void set_scan_len(bit [3:0] value);
    scan_len = value;
  endfunction

  function int pending();
    return owed_expiries.size();
  endfunction

  // Updates the table for one accepted item and queues the expiries of a tick.
  function void note_item(logic [1:0] code, logic [2:0] slot, logic [15:0] per,
                          logic shot);
    int      limit;
    expiry_t tick_expiries [$];
    expiry_t entry;
    case (code)
      stb_pkg::CMD_TICK: begin
        limit = (scan_len > SLOTS) ? SLOTS : int'(scan_len);
        for (int i = 0; i < limit; i++) begin
          if (running[i]) begin
            elapsed[i] = elapsed[i] + 16'd1;
            if (elapsed[i] == period_of[i]) begin
              if (one_shot_of[i])
                running[i] = 1'b0;
              elapsed[i] = '0;
              entry.slot = 3'(i);
              entry.is_last = 1'b0;
              tick_expiries.push_back(entry);
            end
          end
        end
        // The final expiry of the tick carries the end marker.
        if (tick_expiries.size() > 0) begin
          entry = tick_expiries.pop_back();
          entry.is_last = 1'b1;
          tick_expiries.push_back(entry);
        end
        foreach (tick_expiries[k])
          owed_expiries.push_back(tick_expiries[k]);
      end
      stb_pkg::CMD_LOAD: begin
        period_of[slot] = per;
        one_shot_of[slot] = shot;
        elapsed[slot] = '0;
        running[slot] = 1'b1;
      end
      stb_pkg::CMD_STOP: begin
        running[slot] = 1'b0;
      end
      default: begin
        // The spare command code changes nothing.
      end
    endcase
  endfunction

  task report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Compares one accepted result item with the oldest owed expiry.
  task check_fire(logic [2:0] slot, logic is_last);
    expiry_t owed;
    if (owed_expiries.size() == 0) begin
      report($sformatf("unexpected result item: slot %0d last %0b", slot, is_last));
    end else begin
      owed = owed_expiries.pop_front();
      if (slot !== owed.slot)
        report($sformatf("fired_slot %0d, expected %0d", slot, owed.slot));
      if (is_last !== owed.is_last)
        report($sformatf("last_fired %0b, expected %0b (slot %0d)", is_last,
                         owed.is_last, owed.slot));
    end
  endtask

  task check_drained();
    if (owed_expiries.size() != 0)
      report($sformatf("%0d expected result items never arrived",
                       owed_expiries.size()));
  endtask
endclass

module tb;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_LIMIT = 50_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wen;
  logic [3:0]  cfg_wdata;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [1:0]  cmd;
  logic [2:0]  slot_index;
  logic [15:0] period;
  logic        one_shot;
  logic        fire_valid;
  logic        fire_stall = 1'b0;
  logic [2:0]  fired_slot;
  logic        last_fired;

  expiry_scoreboard sb = new();

  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_armed = 1'b0;
  int hold_left = 0;
  int stall_run_left = 0;
  bit stall_level = 1'b0;

  software_timer_bank_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .slot_index (slot_index),
    .period     (period),
    .one_shot   (one_shot),
    .fire_valid (fire_valid),
    .fire_stall (fire_stall),
    .fired_slot (fired_slot),
    .last_fired (last_fired)
  );

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check accepted items, then choose the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && fire_valid && !fire_stall)
      sb.check_fire(fired_slot, last_fired);
    if (hold_left > 0) begin
      hold_left--;
      fire_stall <= 1'b1;
    end else if (hold_armed && fire_valid) begin
      // Long hold-off so that the block fills up and stalls its input.
      hold_armed = 1'b0;
      hold_left = LONG_HOLD;
      fire_stall <= 1'b1;
    end else if (quiet) begin
      fire_stall <= 1'b0;
    end else begin
      if (stall_run_left == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            stall_level = 1'b1;
            stall_run_left = $urandom_range(10, 40);
          end
          1, 2, 3: begin
            stall_level = 1'b1;
            stall_run_left = $urandom_range(1, 3);
          end
          default: begin
            stall_level = 1'b0;
            stall_run_left = $urandom_range(1, 8);
          end
        endcase
      end
      stall_run_left--;
      fire_stall <= stall_level;
    end
  end

  // Idle cycles before the next input item: mostly none, some short, a few long.
  function automatic int sender_gap();
    int pick;
    if (quiet)
      return 0;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      return 0;
    if (pick < 9)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one input item and returns at the edge where it is accepted.
  task automatic send_item(input logic [1:0] code, input logic [2:0] slot,
                           input logic [15:0] per, input logic shot);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= code;
    slot_index <= slot;
    period <= per;
    one_shot <= shot;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_item(code, slot, per, shot);
  endtask

  task automatic tick();
    send_item(stb_pkg::CMD_TICK, 3'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Random item, weighted toward ticks and short periods so that slots expire often.
  task automatic send_random_item(output bit counted);
    int          pick;
    logic [1:0]  code;
    logic [15:0] per;
    pick = $urandom_range(0, 99);
    per = 16'($urandom);
    if (pick < 50) begin
      code = stb_pkg::CMD_TICK;
    end else if (pick < 78) begin
      code = stb_pkg::CMD_LOAD;
      pick = $urandom_range(0, 9);
      if (pick < 7)
        per = 16'($urandom_range(1, 6));
      else if (pick < 9)
        per = 16'($urandom_range(7, 40));
    end else if (pick < 92) begin
      code = stb_pkg::CMD_STOP;
    end else begin
      code = CMD_SPARE;
    end
    send_item(code, 3'($urandom_range(0, 7)), per, 1'($urandom));
    counted = (code != CMD_SPARE);
  endtask

  // Waits until every owed expiry has arrived or DRAIN_LIMIT runs out, then lets the block go idle.
  task automatic settle();
    int waited;
    cmd_valid <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scan_len(input logic [3:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_scan_len(value);
    cfg_wen <= 1'b0;
  endtask

  // Stimulus: reset, directed cases, extreme periods, then random phases.
  initial begin
    logic [3:0] phase_scan [6];
    int         phase_items [6];
    int         done;
    bit         counted;

    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    cmd_valid <= 1'b0;
    cmd <= stb_pkg::CMD_TICK;
    slot_index <= '0;
    period <= '0;
    one_shot <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Stop of an idle slot, spare code, loads, expiries, reload and stop.
    write_scan_len(4'd8);
    send_item(stb_pkg::CMD_STOP, 3'd3, 16'hFFFF, 1'b1);
    send_item(CMD_SPARE, 3'd5, 16'h0001, 1'b0);
    send_item(stb_pkg::CMD_LOAD, 3'd0, 16'd1, 1'b0);
    send_item(stb_pkg::CMD_LOAD, 3'd1, 16'd2, 1'b1);
    send_item(stb_pkg::CMD_LOAD, 3'd7, 16'hFFFF, 1'b1);
    send_item(stb_pkg::CMD_LOAD, 3'd4, 16'd3, 1'b0);
    repeat (3) tick();
    send_item(stb_pkg::CMD_LOAD, 3'd0, 16'd2, 1'b1);
    tick();
    send_item(stb_pkg::CMD_STOP, 3'd4, 16'h0000, 1'b0);
    repeat (2) tick();
    settle();

    // Scan length above the slot count, with every slot expiring on each tick.
    write_scan_len(4'hF);
    for (int i = 0; i < 8; i++)
      send_item(stb_pkg::CMD_LOAD, 3'(i), 16'd1, 1'b0);
    repeat (2) tick();
    settle();

    // Zero scan length: a tick scans nothing.
    write_scan_len(4'd0);
    tick();
    settle();

    // Full-range period and zero period: neither expires within a few ticks.
    write_scan_len(4'd2);
    send_item(stb_pkg::CMD_LOAD, 3'd0, 16'h0000, 1'b0);
    send_item(stb_pkg::CMD_LOAD, 3'd1, 16'hFFFF, 1'b0);
    repeat (4) tick();
    settle();

    // Random phases over several scan lengths.
    phase_scan = '{4'd8, 4'hF, 4'($urandom_range(1, 7)), 4'd0,
                   4'($urandom_range(1, 7)), 4'd8};
    phase_items = '{80, 80, 80, 20, 80, 80};
    for (int ph = 0; ph < 6; ph++) begin
      write_scan_len(phase_scan[ph]);
      quiet = (ph == 4);
      hold_armed = (ph == 0);
      done = 0;
      while (done < phase_items[ph]) begin
        send_random_item(counted);
        if (counted)
          done++;
      end
      settle();
    end
    quiet = 1'b0;

    sb.check_drained();
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
